/* hdl/c2e_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package c2e_pkg;

    // Port widths
    localparam int FACE_W    = 3;
    localparam int TEXEL_W   = 12;
    localparam int DIM_W     = 14;
    localparam int FS_W      = 13;
    localparam int OUT_W     = 13;
    localparam int IDX_W     = 26;
    localparam int CFG_IDX_W = 2;

    // Fixed-point formats
    localparam int FRAC      = 14;
    localparam int HALF_TURN = 32768;
    localparam int INV_GAIN  = 9949;

    // Configuration limits
    localparam int MAX_FACE_SIZE = 4096;
    localparam int MAX_SRC_DIM   = 8192;

    // Divider: quotient bits kept, latency in cycles
    localparam int QBITS   = FRAC + 3;
    localparam int DIV_LAT = QBITS + 2;

    // CORDIC: datapath widths and latency in cycles
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int CW            = 20;
    localparam int AW            = 19;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FACE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    // Arctangent of 2^-i in 2^-16 turn
    localparam logic [13:0] ATAN_TURNS [0:23] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0,
        14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
    };

endpackage

`default_nettype wire

/* hdl/c2e_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Texel position to Q2.14 unit coordinate: floor(t * 2^15 / d) - 1.0, saturated.
// One quotient bit per stage.
module c2e_div (
    input  wire logic                         clk,
    input  wire logic [c2e_pkg::TEXEL_W-1:0]  t,
    input  wire logic [c2e_pkg::TEXEL_W-1:0]  d,
    output logic signed [15:0]                u
);
    import c2e_pkg::*;

    logic [TEXEL_W-1:0] rem_reg [0:QBITS];
    logic [QBITS-1:0]   q_reg   [0:QBITS];
    logic [1:0]         lo_reg  [0:QBITS];
    logic               sat_reg [0:QBITS];
    logic [QBITS-1:0]   q_clamp;

    // Load: upper dividend bits form the first remainder; flag quotients of 2^17 or more
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {2'b00, t[TEXEL_W-1:2]};
        lo_reg[0]  <= t[1:0];
        q_reg[0]   <= '0;
        sat_reg[0] <= {2'b00, t} >= {d, 2'b00};
    end

    // Restoring steps, one quotient bit each
    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic                 nbit;
        logic [TEXEL_W:0]     trial;
        logic                 ge;
        logic [TEXEL_W:0]     diff;

        assign nbit  = (k == 0) ? lo_reg[k][1] : ((k == 1) ? lo_reg[k][0] : 1'b0);
        assign trial = {rem_reg[k], nbit};
        assign ge    = trial >= {1'b0, d};
        assign diff  = trial - {1'b0, d};

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[TEXEL_W-1:0] : trial[TEXEL_W-1:0];
            q_reg[k+1]   <= {q_reg[k][QBITS-2:0], ge};
            lo_reg[k+1]  <= lo_reg[k];
            sat_reg[k+1] <= sat_reg[k];
        end
    end

    // Saturate to 2.0 and shift to [-1, 1]
    assign q_clamp = (sat_reg[QBITS] || q_reg[QBITS] > QBITS'(2 * 16384))
                   ? QBITS'(2 * 16384) : q_reg[QBITS];

    always_ff @(posedge clk)
    begin
        u <= signed'(16'(q_clamp) - 16'd16384);
    end

endmodule

`default_nettype wire

/* hdl/c2e_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vectoring CORDIC: angle of (x, y) in 2^-16 turn and gain-scaled length.
// One micro-rotation per stage.
module c2e_cordic (
    input  wire logic                              clk,
    input  wire logic signed [15:0]                x_in,
    input  wire logic signed [15:0]                y_in,
    output logic signed [c2e_pkg::AW-1:0]          ang,
    output logic        [16:0]                     mag
);
    import c2e_pkg::*;

    logic signed [CW-1:0] x_reg    [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg    [0:CORDIC_STAGES];
    logic signed [AW-1:0] a_reg    [0:CORDIC_STAGES];
    logic                 zero_reg [0:CORDIC_STAGES];

    // Fold the left half-plane onto the right, noting a zero vector
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == 16'sd0) && (y_in == 16'sd0);
        if (x_in < 16'sd0)
        begin
            x_reg[0] <= -CW'(x_in);
            y_reg[0] <= -CW'(y_in);
            a_reg[0] <= (y_in >= 16'sd0) ? AW'(HALF_TURN) : -AW'(HALF_TURN);
        end
        else
        begin
            x_reg[0] <= CW'(x_in);
            y_reg[0] <= CW'(y_in);
            a_reg[0] <= '0;
        end
    end

    // Rotate towards the x axis
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = signed'(AW'(ATAN_TURNS[i]));

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                a_reg[i+1] <= a_reg[i] + da;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                a_reg[i+1] <= a_reg[i] - da;
            end
        end
    end

    // Drop the result of a zero vector
    always_ff @(posedge clk)
    begin
        ang <= zero_reg[CORDIC_STAGES] ? '0 : a_reg[CORDIC_STAGES];
        mag <= (zero_reg[CORDIC_STAGES] || x_reg[CORDIC_STAGES] < 0)
             ? '0 : x_reg[CORDIC_STAGES][16:0];
    end

endmodule

`default_nettype wire

/* hdl/cubemap_texel_to_equirect_address_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cube-face texel to equirectangular source address. A texel word is taken on
// every cycle that start is high; busy is never raised. Each word gives one
// result, shown for one cycle with done high, after passing through a pipelined
// divider for u and v, a register that builds the direction, a CORDIC for theta
// and the x-z radius, a gain-correction register, a second CORDIC for phi, then
// registers for scaling, clamping and the linear index. Write face_size,
// src_width and src_height only while no word is in flight; out-of-range
// values are clamped as they are written.
module cubemap_texel_to_equirect_address_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [c2e_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [c2e_pkg::DIM_W-1:0]       cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [c2e_pkg::FACE_W-1:0]      face,
    input  wire logic [c2e_pkg::TEXEL_W-1:0]     texel_x,
    input  wire logic [c2e_pkg::TEXEL_W-1:0]     texel_y,
    output logic                                 done,
    output logic [c2e_pkg::OUT_W-1:0]            src_col,
    output logic [c2e_pkg::OUT_W-1:0]            src_row,
    output logic [c2e_pkg::IDX_W-1:0]            src_pixel_index
);
    import c2e_pkg::*;

    localparam int LAT   = DIV_LAT + 1 + CORDIC_LAT + 1 + CORDIC_LAT + 3;
    localparam int SKEW  = CORDIC_LAT + 1;

    // Configuration, kept clamped
    logic [TEXEL_W-1:0] denom_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   h_reg;
    logic [FS_W-1:0]    fs_val;
    logic [FS_W-1:0]    fs_clamp;
    logic [DIM_W-1:0]   dim_clamp;

    // Pipeline
    logic [LAT-1:0]          vld_reg;
    logic                    accept;
    logic [FACE_W-1:0]       face_reg [0:DIV_LAT-1];
    logic signed [15:0]      u;
    logic signed [15:0]      v;
    logic signed [15:0]      dx_reg;
    logic signed [15:0]      dy_reg;
    logic signed [15:0]      dz_reg;
    logic signed [15:0]      dx_next;
    logic signed [15:0]      dy_next;
    logic signed [15:0]      dz_next;
    logic signed [15:0]      dyd_reg  [0:SKEW-1];
    logic signed [AW-1:0]    theta;
    logic [16:0]             rad;
    logic [30:0]             rad_prod;
    logic signed [15:0]      radc_reg;
    logic signed [AW-1:0]    thd_reg  [0:SKEW-1];
    logic signed [AW-1:0]    phi;
    logic signed [AW-1:0]    th_c;
    logic [15:0]             phi_c;
    logic [16:0]             tex_u;
    logic [30:0]             colp_reg;
    logic [29:0]             rowp_reg;
    logic [OUT_W-1:0]        col_reg;
    logic [OUT_W-1:0]        row_reg;
    logic [DIM_W-1:0]        w_m1;
    logic [DIM_W-1:0]        h_m1;
    logic [26:0]             idx_sum;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clamp configuration data on write
    assign fs_val    = cfg_data[FS_W-1:0];
    assign fs_clamp  = (fs_val < FS_W'(2)) ? FS_W'(2)
                     : ((fs_val > FS_W'(MAX_FACE_SIZE)) ? FS_W'(MAX_FACE_SIZE) : fs_val);
    assign dim_clamp = (cfg_data == '0) ? DIM_W'(1)
                     : ((cfg_data > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_reg <= TEXEL_W'(511);
            w_reg     <= DIM_W'(2048);
            h_reg     <= DIM_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FACE_SIZE:  denom_reg <= TEXEL_W'(fs_clamp - FS_W'(1));
                REG_SRC_WIDTH:  w_reg     <= dim_clamp;
                REG_SRC_HEIGHT: h_reg     <= dim_clamp;
                default:        ;
            endcase
        end
    end

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    // Texel to unit coordinates
    c2e_div u_div_x (.clk(clk), .t(texel_x), .d(denom_reg), .u(u));
    c2e_div u_div_y (.clk(clk), .t(texel_y), .d(denom_reg), .u(v));

    // Hold the face code until u and v are ready
    always_ff @(posedge clk)
    begin
        face_reg[0] <= face;
        for (int i = 1; i < DIV_LAT; i++)
            face_reg[i] <= face_reg[i-1];
    end

    // Build the direction vector of the face
    always_comb
    begin
        unique case (face_reg[DIV_LAT-1])
            FACE_NX: begin dx_next = -16'sd16384; dy_next = -v; dz_next = u;  end
            FACE_PY: begin dx_next = u; dy_next = 16'sd16384;  dz_next = v;  end
            FACE_NY: begin dx_next = u; dy_next = -16'sd16384; dz_next = -v; end
            FACE_PZ: begin dx_next = u; dy_next = -v; dz_next = 16'sd16384;  end
            FACE_NZ: begin dx_next = -u; dy_next = -v; dz_next = -16'sd16384; end
            default: begin dx_next = 16'sd16384; dy_next = -v; dz_next = -u; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dz_reg <= dz_next;
    end

    // First pass: theta and x-z radius
    c2e_cordic u_cordic_xz (
        .clk(clk), .x_in(dx_reg), .y_in(dz_reg), .ang(theta), .mag(rad)
    );

    // Hold y and theta to line up with the second pass
    always_ff @(posedge clk)
    begin
        dyd_reg[0] <= dy_reg;
        thd_reg[0] <= theta;
        for (int i = 1; i < SKEW; i++)
        begin
            dyd_reg[i] <= dyd_reg[i-1];
            thd_reg[i] <= thd_reg[i-1];
        end
    end

    // Remove the CORDIC gain from the radius, rounding
    assign rad_prod = 31'(rad) * 31'(INV_GAIN) + 31'(8192);

    always_ff @(posedge clk)
    begin
        radc_reg <= signed'(rad_prod[29:14]);
    end

    // Second pass: phi
    c2e_cordic u_cordic_yr (
        .clk(clk), .x_in(dyd_reg[SKEW-1]), .y_in(radc_reg), .ang(phi), .mag()
    );

    // Clamp the angles and scale to source pixels
    assign th_c  = (thd_reg[SKEW-1] < -AW'(HALF_TURN)) ? -AW'(HALF_TURN)
                 : ((thd_reg[SKEW-1] > AW'(HALF_TURN)) ? AW'(HALF_TURN) : thd_reg[SKEW-1]);
    assign tex_u = 17'(th_c + AW'(HALF_TURN));
    assign phi_c = (phi < 0) ? 16'd0
                 : ((phi > AW'(HALF_TURN)) ? 16'(HALF_TURN) : phi[15:0]);

    always_ff @(posedge clk)
    begin
        colp_reg <= 31'(tex_u) * 31'(w_reg);
        rowp_reg <= 30'(phi_c) * 30'(h_reg);
    end

    // Truncate and clamp to the last column and row
    assign w_m1 = w_reg - DIM_W'(1);
    assign h_m1 = h_reg - DIM_W'(1);

    always_ff @(posedge clk)
    begin
        col_reg <= ({1'b0, colp_reg[30:16]} > {2'b00, w_m1}) ? w_m1[OUT_W-1:0]
                                                              : colp_reg[16+OUT_W-1:16];
        row_reg <= ({1'b0, rowp_reg[29:15]} > {2'b00, h_m1}) ? h_m1[OUT_W-1:0]
                                                              : rowp_reg[15+OUT_W-1:15];
    end

    // Linear index and result registers
    assign idx_sum = 27'(row_reg) * 27'(w_reg) + 27'(col_reg);

    always_ff @(posedge clk)
    begin
        src_col         <= col_reg;
        src_row         <= row_reg;
        src_pixel_index <= idx_sum[IDX_W-1:0];
    end

    assign done = vld_reg[LAT-1];

    // Each accepted word is answered by a done strobe at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result strobe out of step with accepted words");

    // Column stays inside the source width
    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, src_col} < w_reg))
        else $error("column beyond source width");

    // Row stays inside the source height
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, src_row} < h_reg))
        else $error("row beyond source height");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import c2e_pkg::*;

    // Expected source address for one texel word
    typedef struct {
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
        logic [IDX_W-1:0] index;
    } addr_t;

    // Directed stimulus row; known_addr marks a typed-in answer
    typedef struct {
        logic [FACE_W-1:0]  face;
        logic [TEXEL_W-1:0] tx;
        logic [TEXEL_W-1:0] ty;
        bit                 known_addr;
        addr_t              addr;
    } texel_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic [FACE_W-1:0]    face;
    logic [TEXEL_W-1:0]   texel_x;
    logic [TEXEL_W-1:0]   texel_y;
    logic                 done;
    logic [OUT_W-1:0]     src_col;
    logic [OUT_W-1:0]     src_row;
    logic [IDX_W-1:0]     src_pixel_index;

    cubemap_texel_to_equirect_address_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .face            (face),
        .texel_x         (texel_x),
        .texel_y         (texel_y),
        .done            (done),
        .src_col         (src_col),
        .src_row         (src_row),
        .src_pixel_index (src_pixel_index)
    );

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    // Arctangent of 2^-i in 2^-16 turn
    localparam int ARCTAN [0:15] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    addr_t addr_queue[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    words_sent = 0;
    bit    idling_on = 1'b1;

    // Mirror of the configuration registers
    int face_size_reg  = 512;
    int src_width_reg  = 2048;
    int src_height_reg = 1024;

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Vectoring rotation: angle of (cx, cy), gain-scaled length in mag
    function automatic int vector_angle(input int cx, input int cy, output int mag);
        int ang;
        int dx;
        int dy;
        ang = 0;
        if (cx == 0 && cy == 0)
        begin
            mag = 0;
            return 0;
        end
        if (cx < 0)
        begin
            ang = (cy >= 0) ? HALF_TURN : -HALF_TURN;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx;
                cy -= dy;
                ang += ARCTAN[i];
            end
            else
            begin
                cx -= dx;
                cy += dy;
                ang -= ARCTAN[i];
            end
        end
        mag = (cx < 0) ? 0 : cx;
        return ang;
    endfunction

    function automatic int unit_coord(input int t, input int denom);
        int q;
        q = (t << 15) / denom;
        if (q > 2 * 16384)
            q = 2 * 16384;
        return q - 16384;
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Source address of one texel under the current register values
    function automatic addr_t equirect_address(input logic [FACE_W-1:0] f,
                                               input int tx, input int ty);
        addr_t  a;
        int     n, w, h, u, v, dx, dy, dz, theta, phi, rad, rad_c, unused;
        longint col, row;
        n = clamp_int(face_size_reg, 2, MAX_FACE_SIZE);
        w = clamp_int(src_width_reg, 1, MAX_SRC_DIM);
        h = clamp_int(src_height_reg, 1, MAX_SRC_DIM);
        u = unit_coord(tx, n - 1);
        v = unit_coord(ty, n - 1);
        case (f)
            FACE_NX: begin dx = -16384; dy = -v;     dz = u;      end
            FACE_PY: begin dx = u;      dy = 16384;  dz = v;      end
            FACE_NY: begin dx = u;      dy = -16384; dz = -v;     end
            FACE_PZ: begin dx = u;      dy = -v;     dz = 16384;  end
            FACE_NZ: begin dx = -u;     dy = -v;     dz = -16384; end
            default: begin dx = 16384;  dy = -v;     dz = -u;     end
        endcase
        theta = vector_angle(dx, dz, rad);
        rad_c = int'((longint'(rad) * INV_GAIN + 8192) >>> 14);
        phi = vector_angle(dy, rad_c, unused);
        theta = clamp_int(theta, -HALF_TURN, HALF_TURN);
        phi = clamp_int(phi, 0, HALF_TURN);
        col = (longint'(theta + HALF_TURN) * w) >>> 16;
        if (col > w - 1)
            col = w - 1;
        row = (longint'(phi) * h) >>> 15;
        if (row > h - 1)
            row = h - 1;
        a.col = col[OUT_W-1:0];
        a.row = row[OUT_W-1:0];
        a.index = IDX_W'(row * w + col);
        return a;
    endfunction

    // Send one texel word and hold it until taken
    task automatic send_texel(input logic [FACE_W-1:0] f, input int tx, input int ty,
                              input bit known_addr, input addr_t typed);
        addr_t a;
        start <= 1'b1;
        face <= f;
        texel_x <= tx[TEXEL_W-1:0];
        texel_y <= ty[TEXEL_W-1:0];
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        a = known_addr ? typed : equirect_address(f, tx, ty);
        addr_queue.push_back(a);
        words_sent++;
        // Random gap after the word
        if (idling_on && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Drop start and wait until every address has come back
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (addr_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[DIM_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FACE_SIZE:  face_size_reg = value & 16'h1FFF;
            REG_SRC_WIDTH:  src_width_reg = value & 16'h3FFF;
            REG_SRC_HEIGHT: src_height_reg = value & 16'h3FFF;
            default: ;
        endcase
    endtask

    task automatic set_config(input int fs, input int w, input int h);
        drain();
        write_reg(REG_FACE_SIZE, fs);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        @(posedge clk);
    endtask

    // Random texels, mostly inside the face
    task automatic random_texels(input int count);
        int    lim;
        int    f;
        addr_t none;
        none = '{default: '0};
        lim = clamp_int(face_size_reg, 2, MAX_FACE_SIZE) - 1;
        if (lim > 4095)
            lim = 4095;
        for (int i = 0; i < count; i++)
        begin
            idling_on = !(words_sent >= 200 && words_sent < 330);
            f = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0)
                send_texel(f[FACE_W-1:0], $urandom_range(0, 4095), $urandom_range(0, 4095),
                           1'b0, none);
            else
                send_texel(f[FACE_W-1:0], $urandom_range(0, lim), $urandom_range(0, lim),
                           1'b0, none);
        end
    endtask

    // Compare each returned address with the oldest expectation
    always @(posedge clk)
    begin
        addr_t e;
        if (rst_n && done)
        begin
            if (addr_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: col %0d row %0d index %0d",
                             src_col, src_row, src_pixel_index);
            end
            else
            begin
                e = addr_queue.pop_front();
                if (src_col !== e.col || src_row !== e.row || src_pixel_index !== e.index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected col %0d row %0d index %0d, got %0d %0d %0d",
                                 e.col, e.row, e.index, src_col, src_row, src_pixel_index);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    texel_row_t texel_rows [0:19];

    initial
    begin
        addr_t none;
        none = '{default: '0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_FACE_SIZE;
        cfg_data = '0;
        start = 1'b0;
        face = FACE_PX;
        texel_x = '0;
        texel_y = '0;

        // Directed rows for face size 3: centre texel is (1,1)
        texel_rows[0]  = '{FACE_PY, 1, 1, 1, '{13'd1024, 13'd0, 26'd1024}};
        texel_rows[1]  = '{FACE_NY, 1, 1, 0, none};
        texel_rows[2]  = '{FACE_PX, 1, 1, 0, none};
        texel_rows[3]  = '{FACE_NX, 1, 1, 0, none};
        texel_rows[4]  = '{FACE_PZ, 1, 1, 0, none};
        texel_rows[5]  = '{FACE_NZ, 1, 1, 0, none};
        texel_rows[6]  = '{3'd6, 1, 1, 0, none};
        texel_rows[7]  = '{3'd7, 0, 2, 0, none};
        texel_rows[8]  = '{FACE_PX, 0, 0, 0, none};
        texel_rows[9]  = '{FACE_PX, 2, 2, 0, none};
        texel_rows[10] = '{FACE_NX, 0, 2, 0, none};
        texel_rows[11] = '{FACE_PY, 0, 0, 0, none};
        texel_rows[12] = '{FACE_PY, 2, 2, 0, none};
        texel_rows[13] = '{FACE_NY, 0, 2, 0, none};
        texel_rows[14] = '{FACE_PZ, 2, 0, 0, none};
        texel_rows[15] = '{FACE_NZ, 0, 0, 0, none};
        texel_rows[16] = '{FACE_PZ, 4095, 4095, 0, none};
        texel_rows[17] = '{FACE_NX, 4095, 0, 0, none};
        texel_rows[18] = '{FACE_NZ, 2, 4095, 0, none};
        texel_rows[19] = '{FACE_PY, 4095, 1, 0, none};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first
        random_texels(40);

        set_config(3, 2048, 1024);
        for (int i = 0; i < 20; i++)
            send_texel(texel_rows[i].face, int'(texel_rows[i].tx), int'(texel_rows[i].ty),
                       texel_rows[i].known_addr, texel_rows[i].addr);

        // Extreme and random settings
        set_config(2, 1, 1);
        random_texels(40);
        set_config(4096, 8192, 8192);
        random_texels(70);
        set_config(0, 0, 0);
        random_texels(30);
        set_config(8191, 16383, 16383);
        random_texels(60);
        set_config(17, 2047, 1023);
        random_texels(80);
        set_config($urandom_range(2, 4096), $urandom_range(1, 8192), $urandom_range(1, 8192));
        random_texels(70);
        set_config($urandom_range(0, 8191), $urandom_range(0, 16383),
                   $urandom_range(0, 16383));
        random_texels(40);

        start <= 1'b0;
        @(posedge clk);
        while (addr_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && addr_queue.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/c2e_pkg.sv
hdl/c2e_div.sv
hdl/c2e_cordic.sv
hdl/cubemap_texel_to_equirect_address_unit.sv
tb/sv/testbench.sv
